/* rtl/core/sfdp_pkg.sv */
// shared types, constants and word positions for the sfdp table decoder
`timescale 1ns / 1ps
`default_nettype none

package sfdp_pkg;

  // table store geometry
  localparam int MAX_TABLE_WORDS = 16;
  localparam int IDX_W           = $clog2(MAX_TABLE_WORDS);

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // dword positions used by the decode
  localparam logic [IDX_W-1:0] WORD_DENSITY    = IDX_W'(1);
  localparam logic [IDX_W-1:0] WORD_ERASE_LO   = IDX_W'(7);
  localparam logic [IDX_W-1:0] WORD_ERASE_HI   = IDX_W'(8);
  localparam logic [IDX_W-1:0] WORD_ERASE_TIME = IDX_W'(9);
  localparam logic [IDX_W-1:0] WORD_PAGE       = IDX_W'(10);
  localparam logic [IDX_W-1:0] WORD_QER        = IDX_W'(14);
  localparam logic [IDX_W-1:0] WORD_FOUR_BYTE  = IDX_W'(15);

  // defaults for the erase settings
  localparam logic [4:0]  DEF_SMALL_LOG2 = 5'd12;
  localparam logic [7:0]  DEF_SMALL_OP   = 8'h20;
  localparam logic [14:0] DEF_SMALL_MS   = 15'd50;
  localparam logic [4:0]  DEF_LARGE_LOG2 = 5'd16;
  localparam logic [7:0]  DEF_LARGE_OP   = 8'hD8;
  localparam logic [14:0] DEF_LARGE_MS   = 15'd150;
  localparam logic [15:0] DEF_PAGE_BYTES = 16'd256;

  // 4-byte addressing threshold (16 MiB)
  localparam logic [31:0] FOUR_BYTE_LIMIT = 32'h0100_0000;

  // erase time unit codes
  typedef enum logic [1:0] {
    UNIT_1MS    = 2'd0,
    UNIT_16MS   = 2'd1,
    UNIT_128MS  = 2'd2,
    UNIT_1000MS = 2'd3
  } erase_unit_t;

  // finished table, as handed from the front to the back
  typedef struct packed {
    logic [IDX_W-1:0] last_index;
    logic [31:0]      density;
    logic [31:0]      erase_lo;
    logic [31:0]      erase_hi;
    logic [31:0]      erase_time;
    logic [31:0]      page;
    logic [31:0]      qer;
    logic [31:0]      four_byte;
  } sfdp_record_t;

  // decoded result
  typedef struct packed {
    logic        status;
    logic [31:0] size_bytes;
    logic [15:0] page_bytes;
    logic [4:0]  small_erase_log2;
    logic [7:0]  small_erase_opcode;
    logic [14:0] small_erase_ms;
    logic [4:0]  large_erase_log2;
    logic [7:0]  large_erase_opcode;
    logic [14:0] large_erase_ms;
    logic [2:0]  quad_enable_method;
    logic        four_byte_needs_wren;
    logic        four_byte_address;
  } sfdp_result_t;

endpackage

`default_nettype wire

/* rtl/core/sfdp_flash_parameter_decoder_top.sv */
// top level of the sfdp basic flash parameter table decoder
`timescale 1ns / 1ps
`default_nettype none

// Takes the dwords of a basic flash parameter table, one transfer per cycle
// while the queue has room, each with its index and a last-word mark; the
// table length is the last index plus one. The last dword snapshots the
// table into a two-entry queue and clears the store, so the store is free
// for a new table. The back end decodes the head of the queue combinationally
// and loads it into the result register when the queue pops, so a result
// passes the queue entry and then the result register. Input ready drops
// only while the queue is full, i.e. while two finished tables wait behind
// a stalled output. Dwords never received read as zero; no clearing pass.
module sfdp_flash_parameter_decoder_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [3:0]  word_index,
  input  wire logic [31:0] word_value,
  input  wire logic        last_word,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             status,
  output logic [31:0]      size_bytes,
  output logic [15:0]      page_bytes,
  output logic [4:0]       small_erase_log2,
  output logic [7:0]       small_erase_opcode,
  output logic [14:0]      small_erase_ms,
  output logic [4:0]       large_erase_log2,
  output logic [7:0]       large_erase_opcode,
  output logic [14:0]      large_erase_ms,
  output logic [2:0]       quad_enable_method,
  output logic             four_byte_needs_wren,
  output logic             four_byte_address
);

  sfdp_pkg::sfdp_record_t push_data;
  sfdp_pkg::sfdp_record_t head;
  sfdp_pkg::sfdp_result_t result;
  logic                   q_full;
  logic                   q_push;
  logic                   q_pop;
  logic                   q_not_empty;

  // store and table hand-off
  sfdp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .word_index (word_index),
    .word_value (word_value),
    .last_word  (last_word),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (push_data)
  );

  // queue of finished tables
  sfdp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (head)
  );

  // decode and result register
  sfdp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_head      (head),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .result      (result)
  );

  // result fields out to ports
  assign status               = result.status;
  assign size_bytes           = result.size_bytes;
  assign page_bytes           = result.page_bytes;
  assign small_erase_log2     = result.small_erase_log2;
  assign small_erase_opcode   = result.small_erase_opcode;
  assign small_erase_ms       = result.small_erase_ms;
  assign large_erase_log2     = result.large_erase_log2;
  assign large_erase_opcode   = result.large_erase_opcode;
  assign large_erase_ms       = result.large_erase_ms;
  assign quad_enable_method   = result.quad_enable_method;
  assign four_byte_needs_wren = result.four_byte_needs_wren;
  assign four_byte_address    = result.four_byte_address;

endmodule

`default_nettype wire

/* rtl/core/sfdp_front.sv */
// front end: dword store and hand-off of each completed table
`timescale 1ns / 1ps
`default_nettype none

module sfdp_front (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [sfdp_pkg::IDX_W-1:0]   word_index,
  input  wire logic [31:0]                  word_value,
  input  wire logic                         last_word,
  input  wire logic                         q_full,
  output logic                              q_push,
  output sfdp_pkg::sfdp_record_t            q_data
);

  logic [31:0]                          store [sfdp_pkg::MAX_TABLE_WORDS];
  logic [sfdp_pkg::MAX_TABLE_WORDS-1:0] valid;
  logic [31:0]                          rd [sfdp_pkg::MAX_TABLE_WORDS];
  logic                                 xfer;

  assign in_ready = !q_full;
  assign xfer     = in_valid && in_ready;
  assign q_push   = xfer && last_word;

  // view of the table as seen with the current dword included
  always_comb begin
    for (int k = 0; k < sfdp_pkg::MAX_TABLE_WORDS; k++) begin
      if (word_index == sfdp_pkg::IDX_W'(k)) begin
        rd[k] = word_value;
      end else if (sfdp_pkg::IDX_W'(k) < word_index && valid[k]) begin
        rd[k] = store[k];
      end else begin
        rd[k] = 32'd0;
      end
    end
  end

  // record of the dwords the decode needs
  always_comb begin
    q_data.last_index = word_index;
    q_data.density    = rd[sfdp_pkg::WORD_DENSITY];
    q_data.erase_lo   = rd[sfdp_pkg::WORD_ERASE_LO];
    q_data.erase_hi   = rd[sfdp_pkg::WORD_ERASE_HI];
    q_data.erase_time = rd[sfdp_pkg::WORD_ERASE_TIME];
    q_data.page       = rd[sfdp_pkg::WORD_PAGE];
    q_data.qer        = rd[sfdp_pkg::WORD_QER];
    q_data.four_byte  = rd[sfdp_pkg::WORD_FOUR_BYTE];
  end

  // valid bits, cleared at the end of every table
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (xfer) begin
      if (last_word) begin
        valid <= '0;
      end else begin
        valid[word_index] <= 1'b1;
      end
    end
  end

  // dword store
  always_ff @(posedge clk) begin
    if (xfer && !last_word) begin
      store[word_index] <= word_value;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/sfdp_queue.sv */
// small fifo of completed tables between front and back
`timescale 1ns / 1ps
`default_nettype none

module sfdp_queue (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   push,
  input  wire sfdp_pkg::sfdp_record_t push_data,
  output logic                        full,
  input  wire logic                   pop,
  output logic                        not_empty,
  output sfdp_pkg::sfdp_record_t      head
);

  sfdp_pkg::sfdp_record_t            entries [sfdp_pkg::QUEUE_DEPTH];
  logic [sfdp_pkg::QPTR_W-1:0]       wr_ptr;
  logic [sfdp_pkg::QPTR_W-1:0]       rd_ptr;
  logic [sfdp_pkg::QCNT_W-1:0]       count;

  assign full      = (count == sfdp_pkg::QCNT_W'(sfdp_pkg::QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == sfdp_pkg::QPTR_W'(sfdp_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == sfdp_pkg::QPTR_W'(sfdp_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/sfdp_back.sv */
// back end: table decode and result register
`timescale 1ns / 1ps
`default_nettype none

module sfdp_back (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   q_not_empty,
  input  wire sfdp_pkg::sfdp_record_t q_head,
  output logic                        q_pop,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output sfdp_pkg::sfdp_result_t      result
);

  sfdp_pkg::sfdp_record_t rec;
  sfdp_pkg::sfdp_result_t dec;

  logic [31:0] size;
  logic [30:0] expo;
  logic [15:0] half [4];
  logic [7:0]  sh [4];
  logic [7:0]  op [4];
  logic        ok [4];
  logic [14:0] ms [4];
  logic [6:0]  tcode;
  logic [14:0] base;
  logic        timed;

  logic        s_found, l_found;
  logic [1:0]  s_idx, l_idx;
  logic [7:0]  s_sh, l_sh;
  logic [7:0]  s_op, l_op;
  logic [14:0] s_ms, l_ms;

  assign rec   = q_head;
  assign q_pop = q_not_empty && (!out_valid || out_ready);
  assign timed = (rec.last_index >= sfdp_pkg::WORD_ERASE_TIME);

  // density to byte size
  always_comb begin
    expo = rec.density[30:0];
    if (rec.density[31]) begin
      if (expo < 31'd3 || expo > 31'd34) begin
        size = 32'd0;
      end else begin
        size = 32'd1 << 5'(expo - 31'd3);
      end
    end else begin
      size = 32'(({1'b0, rec.density} + 33'd1) >> 3);
    end
  end

  // per erase type fields and typical times
  always_comb begin
    half[0] = rec.erase_lo[15:0];
    half[1] = rec.erase_lo[31:16];
    half[2] = rec.erase_hi[15:0];
    half[3] = rec.erase_hi[31:16];
    tcode   = '0;
    base    = '0;
    for (int i = 0; i < 4; i++) begin
      sh[i] = half[i][7:0];
      op[i] = half[i][15:8];
      ok[i] = (sh[i] != 8'd0) && (sh[i] <= 8'd31);
      tcode = rec.erase_time[4 + 7 * i +: 7];
      base  = 15'(tcode[4:0]) + 15'd1;
      unique case (sfdp_pkg::erase_unit_t'(tcode[6:5]))
        sfdp_pkg::UNIT_1MS:    ms[i] = base;
        sfdp_pkg::UNIT_16MS:   ms[i] = base << 4;
        sfdp_pkg::UNIT_128MS:  ms[i] = base << 7;
        sfdp_pkg::UNIT_1000MS: ms[i] = 15'(base * 15'd1000);
        default:               ms[i] = base;
      endcase
    end
  end

  // smallest and largest supported erase types, first one wins a tie
  always_comb begin
    s_found = 1'b0;
    l_found = 1'b0;
    s_idx   = '0;
    l_idx   = '0;
    s_sh    = '0;
    l_sh    = '0;
    s_op    = '0;
    l_op    = '0;
    s_ms    = '0;
    l_ms    = '0;
    for (int i = 0; i < 4; i++) begin
      if (ok[i]) begin
        if (!s_found || sh[i] < s_sh) begin
          s_found = 1'b1;
          s_idx   = 2'(i);
          s_sh    = sh[i];
          s_op    = op[i];
          s_ms    = ms[i];
        end
        if (!l_found || sh[i] > l_sh) begin
          l_found = 1'b1;
          l_idx   = 2'(i);
          l_sh    = sh[i];
          l_op    = op[i];
          l_ms    = ms[i];
        end
      end
    end
  end

  // assemble the decoded result
  always_comb begin
    dec.status     = (size == 32'd0);
    dec.size_bytes = size;
    if (rec.last_index >= sfdp_pkg::WORD_PAGE) begin
      dec.page_bytes = 16'd1 << rec.page[7:4];
    end else begin
      dec.page_bytes = sfdp_pkg::DEF_PAGE_BYTES;
    end
    dec.small_erase_log2   = sfdp_pkg::DEF_SMALL_LOG2;
    dec.small_erase_opcode = sfdp_pkg::DEF_SMALL_OP;
    dec.small_erase_ms     = sfdp_pkg::DEF_SMALL_MS;
    dec.large_erase_log2   = sfdp_pkg::DEF_LARGE_LOG2;
    dec.large_erase_opcode = sfdp_pkg::DEF_LARGE_OP;
    dec.large_erase_ms     = sfdp_pkg::DEF_LARGE_MS;
    if (s_found && l_found && s_idx != l_idx) begin
      dec.small_erase_log2   = s_sh[4:0];
      dec.small_erase_opcode = s_op;
      dec.large_erase_log2   = l_sh[4:0];
      dec.large_erase_opcode = l_op;
      if (timed) begin
        dec.small_erase_ms = s_ms;
        dec.large_erase_ms = l_ms;
      end
    end
    dec.quad_enable_method = (rec.last_index >= sfdp_pkg::WORD_QER) ?
                             rec.qer[22:20] : 3'd0;
    dec.four_byte_needs_wren = (rec.last_index >= sfdp_pkg::WORD_FOUR_BYTE) ?
                               rec.four_byte[25] : 1'b0;
    dec.four_byte_address = (size > sfdp_pkg::FOUR_BYTE_LIMIT);
  end

  // result register and its valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      result <= dec;
    end
  end

endmodule

`default_nettype wire
